// ===== rtl/core/bcs_pkg.sv =====
// Shared constants, codes and control types for the bad-character search block.
`default_nettype none
package bcs_pkg;
    localparam int PAT_DEPTH   = 32;
    localparam int TXT_DEPTH   = 1024;
    localparam int ALPHABET    = 256;
    localparam int MAX_MATCHES = 63;

    localparam int PAT_AW = $clog2(PAT_DEPTH);
    localparam int TXT_AW = $clog2(TXT_DEPTH);
    localparam int SYM_AW = $clog2(ALPHABET);
    localparam int PLEN_W = PAT_AW + 1;
    localparam int TLEN_W = TXT_AW + 1;
    localparam int TBL_W  = 6;
    localparam int CNT_W  = 6;
    localparam int POS_W  = 10;

    localparam logic OP_PAT     = 1'b0;
    localparam logic OP_TEXT    = 1'b1;
    localparam logic KIND_MATCH = 1'b0;
    localparam logic KIND_SUM   = 1'b1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RD    = 9'b000000010,
        S_CMP   = 9'b000000100,
        S_MSH   = 9'b000001000,
        S_MATCH = 9'b000010000,
        S_MNT   = 9'b000100000,
        S_MSH2  = 9'b001000000,
        S_CHK   = 9'b010000000,
        S_SUM   = 9'b100000000
    } t_state;

    typedef struct packed {
        logic load;
        logic rd;
        logic dec_j;
        logic tbl_rd;
        logic shift_mis;
        logic emit_match;
        logic rd_next;
        logic step1;
        logic shift_match;
        logic set_j;
        logic emit_sum;
    } t_cmd;

    typedef struct packed {
        logic eq;
        logic j_zero;
        logic next_in;
        logic chk_ok;
    } t_status;
endpackage
`default_nettype wire

// ===== rtl/core/bcs_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module bcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end
    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== rtl/core/bcs_ctrl.sv =====
// Search sequencer: state machine issuing datapath commands.
`default_nettype none
module bcs_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic             i_op,
    input  wire logic             i_last,
    input  wire bcs_pkg::t_status i_status,
    output bcs_pkg::t_cmd         o_cmd,
    output logic                  o_busy
);
    bcs_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bcs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            bcs_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_op == bcs_pkg::OP_TEXT && i_last) n_state = bcs_pkg::S_CHK;
                end
            end
            bcs_pkg::S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = bcs_pkg::S_CMP;
            end
            bcs_pkg::S_CMP: begin
                if (i_status.eq) begin
                    if (i_status.j_zero) begin
                        n_state = bcs_pkg::S_MATCH;
                    end else begin
                        o_cmd.dec_j = 1'b1;
                        n_state     = bcs_pkg::S_RD;
                    end
                end else begin
                    o_cmd.tbl_rd = 1'b1;
                    n_state      = bcs_pkg::S_MSH;
                end
            end
            bcs_pkg::S_MSH: begin
                o_cmd.shift_mis = 1'b1;
                n_state         = bcs_pkg::S_CHK;
            end
            bcs_pkg::S_MATCH: begin
                o_cmd.emit_match = 1'b1;
                if (i_status.next_in) begin
                    o_cmd.rd_next = 1'b1;
                    n_state       = bcs_pkg::S_MNT;
                end else begin
                    o_cmd.step1 = 1'b1;
                    n_state     = bcs_pkg::S_CHK;
                end
            end
            bcs_pkg::S_MNT: begin
                o_cmd.tbl_rd = 1'b1;
                n_state      = bcs_pkg::S_MSH2;
            end
            bcs_pkg::S_MSH2: begin
                o_cmd.shift_match = 1'b1;
                n_state           = bcs_pkg::S_CHK;
            end
            bcs_pkg::S_CHK: begin
                if (i_status.chk_ok) begin
                    o_cmd.set_j = 1'b1;
                    n_state     = bcs_pkg::S_RD;
                end else begin
                    n_state = bcs_pkg::S_SUM;
                end
            end
            bcs_pkg::S_SUM: begin
                o_cmd.emit_sum = 1'b1;
                n_state        = bcs_pkg::S_IDLE;
            end
            default: n_state = bcs_pkg::S_IDLE;
        endcase
    end

    assign o_busy = (r_state != bcs_pkg::S_IDLE);
endmodule
`default_nettype wire

// ===== rtl/core/bcs_dp.sv =====
// Datapath: stores, last-occurrence table, shift arithmetic and result registers.
`default_nettype none
module bcs_dp (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire bcs_pkg::t_cmd             i_cmd,
    input  wire logic                      i_op,
    input  wire logic [7:0]                i_data,
    input  wire logic                      i_last,
    output bcs_pkg::t_status               o_status,
    output logic                           o_valid,
    output logic                           o_kind,
    output logic [bcs_pkg::POS_W-1:0]      o_position,
    output logic [bcs_pkg::CNT_W-1:0]      o_match_count,
    output logic                           o_found,
    output logic                           o_overflow,
    output logic                           o_done_res
);
    localparam int SW = bcs_pkg::TLEN_W;

    logic [bcs_pkg::PLEN_W-1:0] r_plen;
    logic [bcs_pkg::TLEN_W-1:0] r_tlen;
    logic                       r_closed, r_ovf;
    logic [bcs_pkg::ALPHABET-1:0] r_vld;
    logic                       r_lk_vld;
    logic [SW-1:0]              r_s;
    logic [bcs_pkg::PAT_AW-1:0] r_j;
    logic [bcs_pkg::CNT_W-1:0]  r_cnt;
    logic                       r_out_valid, r_kind, r_found, r_oovf, r_done;
    logic [bcs_pkg::POS_W-1:0]  r_pos;
    logic [bcs_pkg::CNT_W-1:0]  r_ocnt;

    logic [7:0] txt_rdata, pat_rdata;
    logic [bcs_pkg::TBL_W-1:0] tbl_rdata;

    // pattern and text load
    logic [bcs_pkg::PLEN_W-1:0] pidx;
    logic pat_wr, txt_wr;
    assign pidx   = r_closed ? '0 : r_plen;
    assign pat_wr = i_cmd.load && i_op == bcs_pkg::OP_PAT &&
                    pidx < bcs_pkg::PLEN_W'(bcs_pkg::PAT_DEPTH);
    assign txt_wr = i_cmd.load && i_op == bcs_pkg::OP_TEXT &&
                    r_tlen < bcs_pkg::TLEN_W'(bcs_pkg::TXT_DEPTH);

    logic [SW:0] s_plus_j, s_plus_m;
    assign s_plus_j = {1'b0, r_s} + (SW+1)'(r_j);
    assign s_plus_m = {1'b0, r_s} + (SW+1)'(r_plen);

    logic [bcs_pkg::TXT_AW-1:0] txt_addr;
    always_comb begin
        if (i_cmd.load)         txt_addr = r_tlen[bcs_pkg::TXT_AW-1:0];
        else if (i_cmd.rd_next) txt_addr = s_plus_m[bcs_pkg::TXT_AW-1:0];
        else                    txt_addr = s_plus_j[bcs_pkg::TXT_AW-1:0];
    end

    logic [bcs_pkg::SYM_AW-1:0] tbl_addr;
    assign tbl_addr = i_cmd.load ? i_data[bcs_pkg::SYM_AW-1:0]
                                 : txt_rdata[bcs_pkg::SYM_AW-1:0];

    bcs_ram #(.WIDTH(8), .DEPTH(bcs_pkg::TXT_DEPTH)) u_txt (
        .i_clk(i_clk), .i_we(txt_wr), .i_re(i_cmd.rd | i_cmd.rd_next),
        .i_addr(txt_addr), .i_wdata(i_data), .o_rdata(txt_rdata)
    );
    bcs_ram #(.WIDTH(8), .DEPTH(bcs_pkg::PAT_DEPTH)) u_pat (
        .i_clk(i_clk), .i_we(pat_wr), .i_re(i_cmd.rd),
        .i_addr(i_cmd.load ? pidx[bcs_pkg::PAT_AW-1:0] : r_j),
        .i_wdata(i_data), .o_rdata(pat_rdata)
    );
    bcs_ram #(.WIDTH(bcs_pkg::TBL_W), .DEPTH(bcs_pkg::ALPHABET)) u_tbl (
        .i_clk(i_clk), .i_we(pat_wr), .i_re(i_cmd.tbl_rd),
        .i_addr(tbl_addr), .i_wdata(bcs_pkg::TBL_W'(pidx)), .o_rdata(tbl_rdata)
    );

    // last occurrence, minus one when the entry is not valid
    logic signed [7:0] lk, sh_mis, sh_match;
    assign lk       = r_lk_vld ? $signed({2'b00, tbl_rdata}) : -8'sd1;
    assign sh_mis   = $signed({3'b000, r_j}) - lk;
    assign sh_match = $signed({1'b0, 7'(r_plen)}) - lk;

    logic [SW-1:0] s_mis;
    assign s_mis = (sh_mis > 8'sd1) ? r_s + SW'(sh_mis[6:0]) : r_s + SW'(1);

    assign o_status.eq      = (pat_rdata == txt_rdata);
    assign o_status.j_zero  = (r_j == '0);
    assign o_status.next_in = (s_plus_m < (SW+1)'(r_tlen));
    assign o_status.chk_ok  = (r_plen != '0) && (s_plus_m <= (SW+1)'(r_tlen));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen      <= '0;
            r_tlen      <= '0;
            r_closed    <= 1'b0;
            r_ovf       <= 1'b0;
            r_vld       <= '0;
            r_s         <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            if (i_cmd.load) begin
                if (i_op == bcs_pkg::OP_PAT) begin
                    if (pat_wr) begin
                        // a new pattern drops every table entry before this byte lands
                        r_vld <= (r_closed ? '0 : r_vld) |
                                 (bcs_pkg::ALPHABET'(1) << i_data[bcs_pkg::SYM_AW-1:0]);
                        r_plen <= pidx + bcs_pkg::PLEN_W'(1);
                    end else begin
                        if (r_closed) r_vld <= '0;
                        r_plen <= pidx;
                        r_ovf  <= 1'b1;
                    end
                    r_closed <= i_last;
                end else begin
                    if (txt_wr) r_tlen <= r_tlen + bcs_pkg::TLEN_W'(1);
                    else        r_ovf  <= 1'b1;
                end
            end
            if (i_cmd.tbl_rd) r_lk_vld <= r_vld[tbl_addr];
            if (i_cmd.set_j)  r_j <= bcs_pkg::PAT_AW'(r_plen - bcs_pkg::PLEN_W'(1));
            if (i_cmd.dec_j)  r_j <= r_j - bcs_pkg::PAT_AW'(1);
            if (i_cmd.shift_mis)   r_s <= s_mis;
            if (i_cmd.shift_match) r_s <= r_s + SW'(sh_match[6:0]);
            if (i_cmd.step1)       r_s <= r_s + SW'(1);
            if (i_cmd.emit_match) begin
                if (r_cnt < bcs_pkg::CNT_W'(bcs_pkg::MAX_MATCHES)) begin
                    r_cnt       <= r_cnt + bcs_pkg::CNT_W'(1);
                    r_out_valid <= 1'b1;
                    r_kind      <= bcs_pkg::KIND_MATCH;
                    r_pos       <= r_s[bcs_pkg::POS_W-1:0];
                    r_ocnt      <= '0;
                    r_found     <= 1'b0;
                    r_oovf      <= 1'b0;
                    r_done      <= 1'b0;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.emit_sum) begin
                r_out_valid <= 1'b1;
                r_kind      <= bcs_pkg::KIND_SUM;
                r_pos       <= '0;
                r_ocnt      <= r_cnt;
                r_found     <= (r_cnt != '0);
                r_oovf      <= r_ovf;
                r_done      <= 1'b1;
                r_cnt       <= '0;
                r_s         <= '0;
                r_tlen      <= '0;
                r_ovf       <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_kind        = r_kind;
    assign o_position    = r_pos;
    assign o_match_count = r_ocnt;
    assign o_found       = r_found;
    assign o_overflow    = r_oovf;
    assign o_done_res    = r_done;
endmodule
`default_nettype wire

// ===== rtl/core/bad_character_string_search.sv =====
// Boyer-Moore bad-character search: top level joining sequencer and datapath.
// Pattern and text bytes load with start while idle; busy stays low while loading.
// The last text byte starts a search: alignments are checked, bytes read and compared;
// a mismatch or match shifts by the table (a match at the text end shifts by one).
// Results are single-cycle strobes on o_valid; the receiver cannot stall.
// Reset (synchronous, active low) empties pattern, text and table at once.
`default_nettype none
module bad_character_string_search (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_op,
    input  wire logic [7:0]  i_data,
    input  wire logic        i_last,
    output logic             o_valid,
    output logic             o_kind,
    output logic [9:0]       o_position,
    output logic [5:0]       o_match_count,
    output logic             o_found,
    output logic             o_overflow,
    output logic             o_done_res
);
    bcs_pkg::t_cmd    cmd;
    bcs_pkg::t_status status;

    bcs_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_op(i_op),
        .i_last(i_last), .i_status(status), .o_cmd(cmd), .o_busy(busy)
    );

    bcs_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_op(i_op),
        .i_data(i_data), .i_last(i_last), .o_status(status),
        .o_valid(o_valid), .o_kind(o_kind), .o_position(o_position),
        .o_match_count(o_match_count), .o_found(o_found),
        .o_overflow(o_overflow), .o_done_res(o_done_res)
    );
endmodule
`default_nettype wire
